// ----- hw/rtl/crc32bs_pkg.sv -----
// Package for the CRC-32 byte stream block: field widths and the polynomial.
// No dependencies; the fold unit and the top level import it.
package crc32bs_pkg;

	localparam int CRC_W  = 32;
	localparam int BYTE_W = 8;

	// Reflected form of the IEEE 802.3 generator polynomial.
	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

	typedef logic [CRC_W-1:0]  crc_t;
	typedef logic [BYTE_W-1:0] byte_t;

	// One accepted word as it sits in the input stage.
	typedef struct packed {
		byte_t data;
		logic  first;
		logic  last;
	} word_t;

endpackage

// ----- hw/rtl/crc32bs_fold.sv -----
// Combinational fold of one byte into a reflected CRC-32 register value.
// Depends on crc32bs_pkg for the widths and the polynomial.
module crc32bs_fold
	import crc32bs_pkg::*;
(
	input  crc_t  crc_in,
	input  byte_t data_in,
	output crc_t  crc_out
);

	always_comb begin
		crc_t acc;
		acc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
		// Eight bit steps, least significant bit first.
		for (int k = 0; k < BYTE_W; k++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ CRC_POLY;
			end else begin
				acc = acc >> 1;
			end
		end
		crc_out = acc;
	end

endmodule

// ----- hw/rtl/crc32_byte_stream.sv -----
// Top level of the CRC-32 byte stream block: input stage, CRC register, result register.
// Depends on crc32bs_pkg and instantiates crc32bs_fold.
//
// This block computes a reflected CRC-32 (polynomial 0xEDB88320) over messages
// that arrive one byte per word on the input channel. The CRC register starts at
// zero for each message, not all ones, and no final complement is applied, so
// software that expects the common Ethernet/zip value must adapt both ends. A word
// with first_byte set restarts the register from zero before its byte is folded
// in; a word with last_byte set ends the message, and its CRC is sent as one word
// on the output channel, after which the register returns to zero. A byte without
// the first mark keeps folding into the current value, which is zero after reset
// or after a last byte. An empty message has CRC 0 and is not represented here.
// Throughput is one byte per clock cycle, except while a last byte waits for the
// output register as described below. Each accepted word is first captured in an
// input stage register; from there its byte is folded into the CRC register by an
// eight-step shift/xor network, and for a last byte the result is written into
// the output register. That fold network between the input stage and the CRC
// register is the only logic in the loop and sets the clock limit.
// The input side keeps accepting words while a result waits in the output
// register; only a last byte that finds the output register still occupied holds
// the input stage, and then the input channel stalls until the result is taken.
module crc32_byte_stream
	import crc32bs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,

	input  logic  in_valid,
	output logic  in_ready,
	input  byte_t data_byte,
	input  logic  first_byte,
	input  logic  last_byte,

	output logic  out_valid,
	input  logic  out_ready,
	output crc_t  crc_value
);

	// Input stage.
	logic  valid_s1;
	word_t word_s1;

	// Running CRC and the result register.
	crc_t crc_q;
	logic out_valid_q;
	crc_t result_q;

	crc_t fold_in;
	crc_t fold_out;
	logic advance;
	logic in_fire;

	// The stage moves on unless it holds a last byte and the result slot is busy.
	assign advance  = valid_s1 && (!word_s1.last || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	// A first byte folds into zero instead of the running value.
	assign fold_in = word_s1.first ? '0 : crc_q;

	crc32bs_fold u_fold (
		.crc_in  (fold_in),
		.data_in (word_s1.data),
		.crc_out (fold_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			word_s1 <= '{data: data_byte, first: first_byte, last: last_byte};
		end
	end

	// The running value clears after a last byte so the next message starts at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (advance) begin
			crc_q <= word_s1.last ? '0 : fold_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && word_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.last) begin
			result_q <= fold_out;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = result_q;

`ifndef SYNTHESIS
	// A word held in the input stage is never dropped while it waits.
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(word_s1))
		else $error("input stage lost a waiting word");

	// Finishing a message leaves the running CRC at zero.
	a_crc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && word_s1.last |=> crc_q == '0)
		else $error("CRC register not cleared after a last byte");

	// A new result only appears right after a last byte left the input stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && word_s1.last))
		else $error("result produced without a last byte");

	// A last byte never overwrites a result that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance && word_s1.last |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");
`endif

endmodule
